@@ hdl/g2r_pkg.sv @@
// Shared types, register codes and defaults for the gray-to-RGB colorizer.
`timescale 1ns / 1ps
`default_nettype none

package g2r_pkg;

    localparam int DEFAULT_PALETTE_DEPTH = 1024;
    localparam int DEFAULT_SAMPLE_BITS   = 16;

    localparam int LANES     = 3;
    localparam int DIV_STEPS = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_GRAY     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLACK_COLOR  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WHITE_COLOR  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_LAST = 3'd4;

    localparam logic MODE_GRADIENT = 1'b0;
    localparam logic MODE_PALETTE  = 1'b1;

    localparam logic OP_COLORIZE = 1'b0;
    localparam logic OP_WRITE    = 1'b1;

    localparam logic        RESET_MODE         = MODE_GRADIENT;
    localparam logic [15:0] RESET_MAX_GRAY     = 16'd255;
    localparam logic [47:0] RESET_BLACK_COLOR  = 48'h0000_0000_0000;
    localparam logic [47:0] RESET_WHITE_COLOR  = 48'h00FF_00FF_00FF;
    localparam logic [9:0]  RESET_PALETTE_LAST = 10'd255;

    typedef struct packed {
        logic        mode;
        logic [15:0] divisor;
        logic [47:0] black;
        logic [47:0] white;
        logic [9:0]  pal_last;
    } g2r_cfg_t;

    typedef struct packed {
        logic        op;
        logic [9:0]  idx;
        logic [47:0] rgb;
    } g2r_side_t;

    typedef logic [LANES-1:0][31:0] g2r_lanes_t;

endpackage

`default_nettype wire

@@ hdl/gray_to_rgb_colorizer.sv @@
// Top level of the gray-to-RGB colorizer: config registers and pipeline assembly.
`timescale 1ns / 1ps
`default_nettype none

// Takes one transaction per clock on the sample channel while the pixel
// channel keeps taking. A colorize transaction returns one pixel after it
// passes three front stages (clamp, products, blend sum), sixteen
// restoring-division stages that produce one quotient bit each, and the output
// register that also holds the registered palette read. A palette write
// transaction flows through the same pipeline, updates the palette at the
// output end and returns nothing, so reads and writes take effect in arrival
// order. Bubbles collapse; the sample channel stalls only when every stage is
// full and the pixel channel is not taking. Palette contents are undefined
// until written; no clearing pass runs after reset. Config writes are meant
// for idle periods only.
module gray_to_rgb_colorizer #(
    parameter int PALETTE_DEPTH = g2r_pkg::DEFAULT_PALETTE_DEPTH,
    parameter int SAMPLE_BITS   = g2r_pkg::DEFAULT_SAMPLE_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [g2r_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [g2r_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            sample_valid,
    output logic                                 sample_ready,
    input  wire logic                            operation,
    input  wire logic [15:0]                     gray_value,
    input  wire logic [9:0]                      entry_index,
    input  wire logic [15:0]                     entry_red,
    input  wire logic [15:0]                     entry_green,
    input  wire logic [15:0]                     entry_blue,
    output logic                                 pixel_valid,
    input  wire logic                            pixel_ready,
    output logic [15:0]                          red,
    output logic [15:0]                          green,
    output logic [15:0]                          blue
);

    localparam int Steps = g2r_pkg::DIV_STEPS;

    logic        mode_reg;
    logic [15:0] max_gray_reg;
    logic [47:0] black_reg;
    logic [47:0] white_reg;
    logic [9:0]  pal_last_reg;

    g2r_pkg::g2r_cfg_t cfg;

    logic                valid [Steps+1];
    logic                ready [Steps+1];
    g2r_pkg::g2r_side_t  side  [Steps+1];
    g2r_pkg::g2r_lanes_t lanes [Steps+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= g2r_pkg::RESET_MODE;
            max_gray_reg <= g2r_pkg::RESET_MAX_GRAY;
            black_reg    <= g2r_pkg::RESET_BLACK_COLOR;
            white_reg    <= g2r_pkg::RESET_WHITE_COLOR;
            pal_last_reg <= g2r_pkg::RESET_PALETTE_LAST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                g2r_pkg::REG_MODE:         mode_reg     <= cfg_data[0];
                g2r_pkg::REG_MAX_GRAY:     max_gray_reg <= cfg_data[15:0];
                g2r_pkg::REG_BLACK_COLOR:  black_reg    <= cfg_data;
                g2r_pkg::REG_WHITE_COLOR:  white_reg    <= cfg_data;
                g2r_pkg::REG_PALETTE_LAST: pal_last_reg <= cfg_data[9:0];
                default:                   ;
            endcase
        end
    end

    // zero max gray divides as one
    assign cfg.mode     = mode_reg;
    assign cfg.divisor  = (max_gray_reg == 16'd0) ? 16'd1 : max_gray_reg;
    assign cfg.black    = black_reg;
    assign cfg.white    = white_reg;
    assign cfg.pal_last = pal_last_reg;

    g2r_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .operation    (operation),
        .gray_value   (gray_value),
        .entry_index  (entry_index),
        .entry_red    (entry_red),
        .entry_green  (entry_green),
        .entry_blue   (entry_blue),
        .dn_valid     (valid[0]),
        .dn_ready     (ready[0]),
        .dn_side      (side[0]),
        .dn_lanes     (lanes[0])
    );

    for (genvar s = 0; s < Steps; s++)
    begin : g_div
        g2r_div_stage u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .divisor  (cfg.divisor),
            .up_valid (valid[s]),
            .up_ready (ready[s]),
            .up_side  (side[s]),
            .up_lanes (lanes[s]),
            .dn_valid (valid[s+1]),
            .dn_ready (ready[s+1]),
            .dn_side  (side[s+1]),
            .dn_lanes (lanes[s+1])
        );
    end

    g2r_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_mode    (cfg.mode),
        .up_valid    (valid[Steps]),
        .up_ready    (ready[Steps]),
        .up_side     (side[Steps]),
        .up_lanes    (lanes[Steps]),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> pixel_valid && !pixel_ready)
        else $error("sample channel stalled while the pixel channel was free");

endmodule

`default_nettype wire

@@ hdl/g2r_front.sv @@
// Front stages: sample clamp, channel products and blend sums.
`timescale 1ns / 1ps
`default_nettype none

module g2r_front #(
    parameter int SAMPLE_BITS = g2r_pkg::DEFAULT_SAMPLE_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire g2r_pkg::g2r_cfg_t  cfg,
    input  wire logic               sample_valid,
    output logic                    sample_ready,
    input  wire logic               operation,
    input  wire logic [15:0]        gray_value,
    input  wire logic [9:0]         entry_index,
    input  wire logic [15:0]        entry_red,
    input  wire logic [15:0]        entry_green,
    input  wire logic [15:0]        entry_blue,
    output logic                    dn_valid,
    input  wire logic               dn_ready,
    output g2r_pkg::g2r_side_t      dn_side,
    output g2r_pkg::g2r_lanes_t     dn_lanes
);

    localparam logic [15:0] SampleMask = 16'((17'd1 << SAMPLE_BITS) - 17'd1);

    logic                a_valid_reg;
    g2r_pkg::g2r_side_t  a_side_reg;
    logic [15:0]         a_gray_reg;
    logic                b_valid_reg;
    g2r_pkg::g2r_side_t  b_side_reg;
    g2r_pkg::g2r_lanes_t b_prod_a_reg;
    g2r_pkg::g2r_lanes_t b_prod_b_reg;
    logic                c_valid_reg;
    g2r_pkg::g2r_side_t  c_side_reg;
    g2r_pkg::g2r_lanes_t c_work_reg;

    logic                a_ready;
    logic                b_ready;
    logic                c_ready;
    logic [15:0]         gray_cut;
    logic [15:0]         gray_next;
    g2r_pkg::g2r_side_t  side_next;
    logic [15:0]         diff;
    logic [g2r_pkg::LANES-1:0][15:0] op_a;
    logic [g2r_pkg::LANES-1:0][15:0] op_b;
    logic [g2r_pkg::LANES-1:0][15:0] op_c;
    logic [g2r_pkg::LANES-1:0][15:0] op_d;
    g2r_pkg::g2r_lanes_t prod_a;
    g2r_pkg::g2r_lanes_t prod_b;
    g2r_pkg::g2r_lanes_t sum_next;

    assign c_ready      = !c_valid_reg || dn_ready;
    assign b_ready      = !b_valid_reg || c_ready;
    assign a_ready      = !a_valid_reg || b_ready;
    assign sample_ready = a_ready;

    assign gray_cut  = gray_value & SampleMask;
    assign gray_next = (gray_cut > cfg.divisor) ? cfg.divisor : gray_cut;

    assign side_next.op  = operation;
    assign side_next.idx = entry_index;
    assign side_next.rgb = {entry_red, entry_green, entry_blue};

    assign diff = cfg.divisor - a_gray_reg;

    always_comb
    begin
        for (int k = 0; k < g2r_pkg::LANES; k++)
        begin
            if (cfg.mode == g2r_pkg::MODE_PALETTE && k == 0)
            begin
                op_a[k] = a_gray_reg;
                op_b[k] = 16'(cfg.pal_last);
                op_c[k] = '0;
                op_d[k] = '0;
            end
            else
            begin
                op_a[k] = cfg.black[(g2r_pkg::LANES-1-k)*16 +: 16];
                op_b[k] = diff;
                op_c[k] = cfg.white[(g2r_pkg::LANES-1-k)*16 +: 16];
                op_d[k] = a_gray_reg;
            end
            prod_a[k]   = op_a[k] * op_b[k];
            prod_b[k]   = op_c[k] * op_d[k];
            sum_next[k] = b_prod_a_reg[k] + b_prod_b_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= sample_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_side_reg <= side_next;
            a_gray_reg <= gray_next;
        end
        if (b_ready)
        begin
            b_side_reg   <= a_side_reg;
            b_prod_a_reg <= prod_a;
            b_prod_b_reg <= prod_b;
        end
        if (c_ready)
        begin
            c_side_reg <= b_side_reg;
            c_work_reg <= sum_next;
        end
    end

    assign dn_valid = c_valid_reg;
    assign dn_side  = c_side_reg;
    assign dn_lanes = c_work_reg;

endmodule

`default_nettype wire

@@ hdl/g2r_div_stage.sv @@
// One restoring-division step on all three lanes, with its own pipeline register.
`timescale 1ns / 1ps
`default_nettype none

module g2r_div_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [15:0]         divisor,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire g2r_pkg::g2r_side_t  up_side,
    input  wire g2r_pkg::g2r_lanes_t up_lanes,
    output logic                     dn_valid,
    input  wire logic                dn_ready,
    output g2r_pkg::g2r_side_t       dn_side,
    output g2r_pkg::g2r_lanes_t      dn_lanes
);

    logic                valid_reg;
    g2r_pkg::g2r_side_t  side_reg;
    g2r_pkg::g2r_lanes_t work_reg;

    logic [g2r_pkg::LANES-1:0][16:0] trial;
    logic [g2r_pkg::LANES-1:0][16:0] rem;
    logic [g2r_pkg::LANES-1:0]       fits;
    g2r_pkg::g2r_lanes_t             work_next;

    assign up_ready = !valid_reg || dn_ready;

    // work holds {partial remainder, unused numerator bits, quotient bits}
    always_comb
    begin
        for (int k = 0; k < g2r_pkg::LANES; k++)
        begin
            trial[k]     = up_lanes[k][31:15];
            fits[k]      = trial[k] >= {1'b0, divisor};
            rem[k]       = fits[k] ? (trial[k] - {1'b0, divisor}) : trial[k];
            work_next[k] = {rem[k][15:0], up_lanes[k][14:0], fits[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            side_reg <= up_side;
            work_reg <= work_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_side  = side_reg;
    assign dn_lanes = work_reg;

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !dn_ready |=> valid_reg && $stable(side_reg) && $stable(work_reg))
        else $error("division stage lost or changed a stalled transaction");

endmodule

`default_nettype wire

@@ hdl/g2r_palette.sv @@
// Palette memory, entry writes and the output pixel register.
`timescale 1ns / 1ps
`default_nettype none

module g2r_palette #(
    parameter int PALETTE_DEPTH = g2r_pkg::DEFAULT_PALETTE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_mode,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire g2r_pkg::g2r_side_t  up_side,
    input  wire g2r_pkg::g2r_lanes_t up_lanes,
    output logic                     pixel_valid,
    input  wire logic                pixel_ready,
    output logic [15:0]              red,
    output logic [15:0]              green,
    output logic [15:0]              blue
);

    localparam int          AW       = $clog2(PALETTE_DEPTH);
    localparam logic [15:0] LastAddr = 16'(PALETTE_DEPTH - 1);
    localparam logic [16:0] DepthW   = 17'(PALETTE_DEPTH);

    logic [47:0] mem [PALETTE_DEPTH];

    logic        out_valid_reg;
    logic        sel_reg;
    logic [47:0] pal_reg;
    logic [47:0] grad_reg;

    logic          wr_item;
    logic          rd_item;
    logic          slot_free;
    logic          load;
    logic [15:0]   quot;
    logic [AW-1:0] rd_addr;
    logic [16:0]   widx;
    logic          wr_ok;
    logic [AW-1:0] wr_addr;
    logic [47:0]   pixel;

    assign wr_item   = up_valid && (up_side.op == g2r_pkg::OP_WRITE);
    assign rd_item   = up_valid && (up_side.op == g2r_pkg::OP_COLORIZE);
    assign slot_free = !out_valid_reg || pixel_ready;
    assign up_ready  = wr_item || slot_free;
    assign load      = rd_item && slot_free;

    assign quot    = up_lanes[0][15:0];
    assign rd_addr = (quot > LastAddr) ? LastAddr[AW-1:0] : quot[AW-1:0];
    assign widx    = 17'(up_side.idx);
    assign wr_ok   = widx < DepthW;
    assign wr_addr = widx[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_item && wr_ok)
            mem[wr_addr] <= up_side.rgb;
        if (load)
            pal_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grad_reg <= {up_lanes[0][15:0], up_lanes[1][15:0], up_lanes[2][15:0]};
            sel_reg  <= cfg_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (slot_free)
            out_valid_reg <= rd_item;
    end

    assign pixel       = (sel_reg == g2r_pkg::MODE_PALETTE) ? pal_reg : grad_reg;
    assign pixel_valid = out_valid_reg;
    assign red         = pixel[47:32];
    assign green       = pixel[31:16];
    assign blue        = pixel[15:0];

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr_item |=> out_valid_reg == $past(out_valid_reg && !pixel_ready))
        else $error("palette write transaction touched the output register");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(rd_item))
        else $error("pixel appeared without a colorize transaction");

endmodule

`default_nettype wire

@@ verif/gray_to_rgb_colorizer_tb.sv @@
// Self-checking testbench for gray_to_rgb_colorizer: gradient and palette colorizing.
`timescale 1ns / 1ps

module gray_to_rgb_colorizer_tb;

    localparam int PAL_DEPTH     = g2r_pkg::DEFAULT_PALETTE_DEPTH;
    localparam int SETTLE_CYCLES = 40;
    localparam int ITEM_TARGET   = 700;

    typedef struct packed {
        logic        op;
        logic [15:0] gray;
        logic [9:0]  slot;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } sample_t;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } pixel_t;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            cfg_write    = 1'b0;
    logic [g2r_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [g2r_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                            sample_valid = 1'b0;
    logic                            sample_ready;
    logic                            operation    = g2r_pkg::OP_COLORIZE;
    logic [15:0]                     gray_value   = '0;
    logic [9:0]                      entry_index  = '0;
    logic [15:0]                     entry_red    = '0;
    logic [15:0]                     entry_green  = '0;
    logic [15:0]                     entry_blue   = '0;
    logic                            pixel_valid;
    logic                            pixel_ready  = 1'b0;
    logic [15:0]                     red;
    logic [15:0]                     green;
    logic [15:0]                     blue;

    sample_t pending_samples[$];
    pixel_t  expected_pixels[$];
    sample_t next_sample;
    pixel_t  want_pixel;

    // shadow copy of the block's registers and palette
    logic        cur_mode  = g2r_pkg::RESET_MODE;
    logic [15:0] cur_max   = g2r_pkg::RESET_MAX_GRAY;
    logic [47:0] cur_black = g2r_pkg::RESET_BLACK_COLOR;
    logic [47:0] cur_white = g2r_pkg::RESET_WHITE_COLOR;
    logic [9:0]  cur_last  = g2r_pkg::RESET_PALETTE_LAST;
    logic [47:0] palette_model [PAL_DEPTH];
    bit          slot_loaded   [PAL_DEPTH];

    bit calm       = 1'b0;
    int mismatches = 0;
    int item_total = 0;

    gray_to_rgb_colorizer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .operation    (operation),
        .gray_value   (gray_value),
        .entry_index  (entry_index),
        .entry_red    (entry_red),
        .entry_green  (entry_green),
        .entry_blue   (entry_blue),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] eff_max();
        return (cur_max == 16'd0) ? 32'd1 : 32'(cur_max);
    endfunction

    function automatic logic [31:0] clamp_gray(input logic [15:0] gray);
        logic [31:0] m;
        m = eff_max();
        return (32'(gray) > m) ? m : 32'(gray);
    endfunction

    function automatic logic [9:0] palette_slot(input logic [15:0] gray);
        logic [31:0] m;
        logic [31:0] g;
        logic [31:0] idx;
        m = eff_max();
        g = clamp_gray(gray);
        if (m == 32'(cur_last))
        begin
            idx = g;
        end
        else
        begin
            idx = (g * 32'(cur_last)) / m;
        end
        if (idx >= PAL_DEPTH)
        begin
            idx = PAL_DEPTH - 1;
        end
        return idx[9:0];
    endfunction

    function automatic logic [15:0] blend(input logic [15:0] c0, input logic [15:0] c1,
                                          input logic [31:0] g, input logic [31:0] m);
        logic [63:0] acc;
        acc = 64'(c0) * 64'(m - g) + 64'(c1) * 64'(g);
        return 16'(acc / 64'(m));
    endfunction

    function automatic pixel_t colorize(input logic [15:0] gray);
        pixel_t      px;
        logic [31:0] m;
        logic [31:0] g;
        m = eff_max();
        g = clamp_gray(gray);
        if (cur_mode == g2r_pkg::MODE_GRADIENT)
        begin
            px.r = blend(cur_black[47:32], cur_white[47:32], g, m);
            px.g = blend(cur_black[31:16], cur_white[31:16], g, m);
            px.b = blend(cur_black[15:0], cur_white[15:0], g, m);
        end
        else
        begin
            px = palette_model[palette_slot(gray)];
        end
        return px;
    endfunction

    function automatic logic [47:0] rand_color();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return 48'({$urandom(), $urandom()});
        endcase
    endfunction

    task automatic write_reg(input logic [g2r_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [47:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            g2r_pkg::REG_MODE:         cur_mode  = value[0];
            g2r_pkg::REG_MAX_GRAY:     cur_max   = value[15:0];
            g2r_pkg::REG_BLACK_COLOR:  cur_black = value;
            g2r_pkg::REG_WHITE_COLOR:  cur_white = value;
            g2r_pkg::REG_PALETTE_LAST: cur_last  = value[9:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        do @(negedge clk);
        while (pending_samples.size() != 0 || sample_valid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic setup(input logic m, input logic [15:0] maxg, input logic [47:0] blk,
                         input logic [47:0] wht, input logic [9:0] last);
        drain();
        write_reg(g2r_pkg::REG_MODE, 48'(m));
        write_reg(g2r_pkg::REG_MAX_GRAY, 48'(maxg));
        write_reg(g2r_pkg::REG_BLACK_COLOR, blk);
        write_reg(g2r_pkg::REG_WHITE_COLOR, wht);
        write_reg(g2r_pkg::REG_PALETTE_LAST, 48'(last));
        @(negedge clk);
    endtask

    task automatic push_write(input logic [9:0] slot, input logic [47:0] rgb);
        sample_t s;
        s = '{op: g2r_pkg::OP_WRITE, gray: 16'($urandom()), slot: slot,
              r: rgb[47:32], g: rgb[31:16], b: rgb[15:0]};
        slot_loaded[slot] = 1'b1;
        pending_samples.push_back(s);
        item_total++;
    endtask

    // palette reads only hit entries loaded earlier; load on demand
    task automatic push_colorize(input logic [15:0] gray);
        sample_t    s;
        logic [9:0] slot;
        slot = palette_slot(gray);
        if (cur_mode == g2r_pkg::MODE_PALETTE && !slot_loaded[slot])
        begin
            push_write(slot, rand_color());
        end
        s = '{op: g2r_pkg::OP_COLORIZE, gray: gray, slot: 10'($urandom()),
              r: 16'($urandom()), g: 16'($urandom()), b: 16'($urandom())};
        pending_samples.push_back(s);
        item_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            if (sample_valid && sample_ready)
            begin
                if (operation == g2r_pkg::OP_WRITE)
                begin
                    palette_model[entry_index] = {entry_red, entry_green, entry_blue};
                end
                else
                begin
                    expected_pixels.push_back(colorize(gray_value));
                end
            end
            if (!sample_valid || sample_ready)
            begin
                if (pending_samples.size() != 0 && (calm || $urandom_range(0, 99) >= 25))
                begin
                    next_sample = pending_samples.pop_front();
                    operation    <= next_sample.op;
                    gray_value   <= next_sample.gray;
                    entry_index  <= next_sample.slot;
                    entry_red    <= next_sample.r;
                    entry_green  <= next_sample.g;
                    entry_blue   <= next_sample.b;
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_ready <= 1'b0;
        end
        else
        begin
            if (pixel_valid && pixel_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected pixel transaction: r=%h g=%h b=%h",
                                 red, green, blue);
                    end
                end
                else
                begin
                    want_pixel = expected_pixels.pop_front();
                    if (want_pixel.r !== red || want_pixel.g !== green ||
                        want_pixel.b !== blue)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("pixel mismatch: expected r=%h g=%h b=%h, %s",
                                     want_pixel.r, want_pixel.g, want_pixel.b,
                                     $sformatf("got r=%h g=%h b=%h", red, green, blue));
                        end
                    end
                end
            end
            pixel_ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    initial
    begin
        int          phase;
        int          burst;
        logic        m;
        logic [15:0] maxg;
        logic [9:0]  last;
        logic [31:0] top;
        logic [15:0] gray;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults
        push_colorize(16'd0);
        push_colorize(16'd255);
        push_colorize(16'd256);
        push_colorize(16'hFFFF);
        push_colorize(16'd128);
        push_colorize(16'd1);

        setup(g2r_pkg::MODE_GRADIENT, 16'hFFFF, '1, '0, 10'd0);
        push_colorize(16'd0);
        push_colorize(16'hFFFF);
        push_colorize(16'h7FFF);
        push_colorize(16'd1);

        // zero max gray acts as one
        setup(g2r_pkg::MODE_GRADIENT, 16'd0, 48'h1234_8000_FFFF, 48'hFFFF_0001_0000, 10'd0);
        push_colorize(16'd0);
        push_colorize(16'd1);
        push_colorize(16'hFFFF);

        setup(g2r_pkg::MODE_PALETTE, 16'd1, '0, '0, 10'd0);
        push_write(10'd0, 48'hAAAA_5555_FFFF);
        push_colorize(16'd0);
        push_colorize(16'hFFFF);

        // max gray equal to the last index
        setup(g2r_pkg::MODE_PALETTE, 16'd1023, '0, '0, 10'd1023);
        push_write(10'd1023, '1);
        push_write(10'd511, '0);
        push_colorize(16'd1023);
        push_colorize(16'd511);
        push_colorize(16'hFFFF);

        setup(g2r_pkg::MODE_PALETTE, 16'hFFFF, '0, '0, 10'd1023);
        push_colorize(16'hFFFF);
        push_colorize(16'd0);

        phase = 0;
        while (item_total < ITEM_TARGET)
        begin
            m = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: last = 10'd0;
                1: last = 10'd1023;
                2: last = 10'($urandom());
                default: last = 10'($urandom_range(1, 15));
            endcase
            case ($urandom_range(0, 9))
                0: maxg = 16'd0;
                1: maxg = 16'd1;
                2: maxg = 16'hFFFF;
                3: maxg = 16'(last);
                4: maxg = 16'($urandom());
                default: maxg = 16'($urandom_range(1, 300));
            endcase
            setup(m, maxg, rand_color(), rand_color(), last);
            calm = (phase == 3 || phase == 4);
            top = eff_max();
            burst = $urandom_range(30, 70);
            repeat (burst)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    push_write(10'($urandom()), rand_color());
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0: gray = 16'd0;
                        1: gray = 16'(top);
                        2: gray = (top >= 32'hFFFF) ? 16'hFFFF : 16'(top + 1);
                        3, 4: gray = 16'($urandom());
                        default: gray = 16'($urandom_range(0, top));
                    endcase
                    push_colorize(gray);
                end
            end
            phase++;
        end

        drain();
        if (mismatches == 0)
        begin
            $display("gray_to_rgb_colorizer regression: pass");
        end
        else
        begin
            $display("gray_to_rgb_colorizer regression: fail");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("gray_to_rgb_colorizer regression: fail");
        $finish;
    end

endmodule
